// ===== src/udla_pkg.sv =====
// Package for the ungapped diagonal local alignment block.
// Sizes, lane and result types, cell control and state codes; no dependencies.
package udla_pkg;

  // Word store and counter sizes
  localparam int MAX_LEN = 1024;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int LEN_W   = ADDR_W + 1;
  localparam int RUN_W   = LEN_W + 1;   // signed run sum, -1 .. MAX_LEN
  localparam int OFF_W   = LEN_W + 2;   // signed diagonal offset
  localparam int TAU_W   = LEN_W + 2;   // feed time within a pass

  // Row of cells: one diagonal per cell in each pass
  localparam int NCELL   = 256;
  localparam int CNT_W   = $clog2(NCELL);

  // Result fields
  localparam int SCORE_W = 13;
  localparam int SHIFT_W = 11;
  localparam int IDX_W   = 10;
  localparam int IN_W    = 16;
  localparam int OUT_W   = 48;

  // Symbol of the first word travelling along the row
  typedef struct packed {
    logic              vld;
    logic [7:0]        sym;
    logic [ADDR_W-1:0] idx;
  } alane_t;

  // Symbol of the second word travelling along the row
  typedef struct packed {
    logic       vld;
    logic [7:0] sym;
  } blane_t;

  // Best run found on one diagonal
  typedef struct packed {
    logic [RUN_W-1:0]  score;
    logic [ADDR_W-1:0] first_idx;
    logic [ADDR_W-1:0] last_idx;
  } res_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic clear;
    logic drain;
  } ctrl_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_PREP,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

endpackage

// ===== src/udla_cell.sv =====
// One cell of the alignment row: max-subarray scan of a single diagonal.
// Depends on udla_pkg for lane, result and control types.
module udla_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  udla_pkg::ctrl_t ctrl_i,
  input  udla_pkg::alane_t a_i,
  input  udla_pkg::blane_t b_i,
  input  udla_pkg::res_t  res_i,
  output udla_pkg::alane_t a_o,
  output udla_pkg::blane_t b_o,
  output udla_pkg::res_t  res_o
);
  import udla_pkg::*;

  alane_t            a_q;
  blane_t            b1_q, b2_q;
  logic [RUN_W-1:0]  run_q, run_d;
  logic [ADDR_W-1:0] rstart_q, rstart_d;
  logic              started_q;
  res_t              res_q;

  logic pair, restart, better;
  logic [RUN_W-1:0] base;

  // Step of the scan on the pair held here
  always_comb begin
    pair     = a_q.vld & b2_q.vld;
    restart  = !started_q || run_q[RUN_W-1];
    base     = restart ? '0 : run_q;
    rstart_d = restart ? a_q.idx : rstart_q;
    run_d    = (a_q.sym == b2_q.sym) ? base + RUN_W'(1) : base - RUN_W'(1);
    better   = $signed(run_d) > $signed(res_q.score);
  end

  // Lanes move on every cycle unless clear is set: first word one stage, second word two
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q       <= '0;
      b1_q      <= '0;
      b2_q      <= '0;
      run_q     <= '0;
      rstart_q  <= '0;
      started_q <= 1'b0;
      res_q     <= '0;
    end else if (ctrl_i.clear) begin
      a_q.vld   <= 1'b0;
      b1_q.vld  <= 1'b0;
      b2_q.vld  <= 1'b0;
      run_q     <= '0;
      started_q <= 1'b0;
      res_q     <= '{score: '1, first_idx: '0, last_idx: '0};
    end else begin
      a_q  <= a_i;
      b1_q <= b_i;
      b2_q <= b1_q;
      if (ctrl_i.drain) begin
        res_q <= res_i;
      end else if (pair) begin
        started_q <= 1'b1;
        run_q     <= run_d;
        rstart_q  <= rstart_d;
        if (better) begin
          res_q <= '{score: run_d, first_idx: rstart_d, last_idx: a_q.idx};
        end
      end
    end
  end

  assign a_o   = a_q;
  assign b_o   = b2_q;
  assign res_o = res_q;

endmodule

// ===== src/udla_row.sv =====
// Row of alignment cells; lanes run forward, results drain back to cell 0.
// Depends on udla_pkg and udla_cell.
module udla_row (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  udla_pkg::ctrl_t ctrl_i,
  input  udla_pkg::alane_t a_i,
  input  udla_pkg::blane_t b_i,
  output udla_pkg::res_t  res_o
);
  import udla_pkg::*;

  alane_t a_w   [NCELL+1];
  blane_t b_w   [NCELL+1];
  res_t   res_w [NCELL+1];

  assign a_w[0]       = a_i;
  assign b_w[0]       = b_i;
  // beyond the far end nothing was found
  assign res_w[NCELL] = '{score: '1, first_idx: '0, last_idx: '0};

  for (genvar d = 0; d < NCELL; d++) begin : g_cell
    udla_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl_i),
      .a_i    (a_w[d]),
      .b_i    (b_w[d]),
      .res_i  (res_w[d+1]),
      .a_o    (a_w[d+1]),
      .b_o    (b_w[d+1]),
      .res_o  (res_w[d])
    );
  end

  assign res_o = res_w[0];

endmodule

// ===== src/ungapped_diagonal_local_alignment.sv =====
// Ungapped local alignment over all diagonals of two loaded symbol strings.
// Holds the word stores and the pass sequencer; depends on udla_pkg, udla_row.
//
// Usage: symbols stream in on the slave channel, one transfer per cycle while
// loading; tdata[0] picks the word (0 first, 1 second), tdata[8:1] is the symbol.
// A transfer with tlast set stores its symbol and starts the alignment; the
// input is then held off until the result has been placed in the output
// register. Symbols beyond 1024 per word are dropped.
// The alignment runs in passes over a row of 256 cells, each cell scanning one
// diagonal. P = ceil((n1 + n2 - 1) / 256) passes (none if that is not positive);
// a pass has a set-up state, a feed state and a drain state; the feed grows with
// n1 and with A <= n2, the skew of the first word. The feed is set by the speed
// of the row; the drain reads cell results out one a cycle through cell 0.
// The result waits in the output register until taken; while it waits, symbols
// are loaded and aligned anew, but a further result is held in the completion
// state, where no symbols are taken.
// Reset empties both words and drops any pending result; no clearing pass.
module ungapped_diagonal_local_alignment (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // [0] mode, [8:1] symbol, [15:9] zero
  input  logic [udla_pkg::IN_W-1:0]  s_axis_tdata_i,
  input  logic                        s_axis_tlast_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // [12:0] score, [23:13] shift, [33:24] start_index, [43:34] end_index, zero
  output logic [udla_pkg::OUT_W-1:0] m_axis_tdata_o
);
  import udla_pkg::*;

  state_e state_q, state_d;

  logic [7:0] first_word  [MAX_LEN];
  logic [7:0] second_word [MAX_LEN];

  logic [LEN_W-1:0]  n1_q, n2_q;
  logic [OFF_W-1:0]  off_q;
  logic [TAU_W-1:0]  tau_q, a_base_q, b_base_q, tend_q;
  logic [CNT_W-1:0]  k_q;
  logic [RUN_W-1:0]  gb_q;
  logic [OFF_W-1:0]  gsh_q;
  logic [ADDR_W-1:0] gst_q, gend_q;
  logic              m_vld_q;
  logic [OUT_W-1:0]  m_data_q;
  alane_t            a_feed_q;
  blane_t            b_feed_q;

  ctrl_t ctrl;
  res_t  row_res;

  logic s_xfer, m_xfer, in_mode, wr1, wr2, done_ok, off_end, k_end;
  logic [7:0]       in_sym;
  logic [OFF_W-1:0] lim, offp1, cshift;
  logic [TAU_W-1:0] a_rel, b_rel, a_base_d, b_base_d;
  logic a_ok, b_ok, prio, replace;

  // Handshakes and decode
  always_comb begin
    s_xfer  = s_axis_tvalid_i & s_axis_tready_o;
    m_xfer  = m_vld_q & m_axis_tready_i;
    in_mode = s_axis_tdata_i[0];
    in_sym  = s_axis_tdata_i[8:1];
    wr1     = s_xfer && !in_mode && (n1_q < LEN_W'(MAX_LEN));
    wr2     = s_xfer && in_mode && (n2_q < LEN_W'(MAX_LEN));
    done_ok = !m_vld_q || m_axis_tready_i;
    lim     = OFF_W'(1) - OFF_W'(n1_q);
    off_end = $signed(off_q) < $signed(lim);
    k_end   = k_q == CNT_W'(NCELL - 1);
  end

  // Pass skew: cell d scans shift off - d
  always_comb begin
    offp1 = off_q + OFF_W'(1);
    if (!offp1[OFF_W-1]) begin
      a_base_d = TAU_W'(offp1);
      b_base_d = '0;
    end else begin
      a_base_d = '0;
      b_base_d = TAU_W'(-offp1);
    end
  end

  // Feed addresses
  always_comb begin
    a_rel = tau_q - a_base_q;
    b_rel = tau_q - b_base_q;
    a_ok  = (state_q == ST_RUN) && (tau_q >= a_base_q) && (a_rel < TAU_W'(n1_q));
    b_ok  = (state_q == ST_RUN) && (tau_q >= b_base_q) && (b_rel < TAU_W'(n2_q));
  end

  // Folding of drained diagonal results; shift 0 wins ties, then lowest shift
  always_comb begin
    cshift  = off_q - OFF_W'(k_q);
    prio    = (gsh_q != '0) &&
              ((cshift == '0) || ($signed(cshift) < $signed(gsh_q)));
    replace = ($signed(row_res.score) > $signed(gb_q)) ||
              ((row_res.score == gb_q) && ($signed(row_res.score) > 0) && prio);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:  if (s_xfer && s_axis_tlast_i) state_d = ST_INIT;
      ST_INIT:  state_d = ST_PREP;
      ST_PREP:  state_d = off_end ? ST_DONE : ST_RUN;
      ST_RUN:   if (tau_q == tend_q) state_d = ST_DRAIN;
      ST_DRAIN: if (k_end) state_d = ST_PREP;
      ST_DONE:  if (done_ok) state_d = ST_LOAD;
      default:  state_d = ST_LOAD;
    endcase
  end

  // State outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    ctrl            = '0;
    unique case (state_q)
      ST_LOAD:  s_axis_tready_o = 1'b1;
      ST_PREP:  ctrl.clear = 1'b1;
      ST_DRAIN: ctrl.drain = 1'b1;
      default:  ctrl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_LOAD;
    else         state_q <= state_d;
  end

  // Word stores
  always_ff @(posedge clk_i) begin
    if (wr1) first_word[n1_q[ADDR_W-1:0]] <= in_sym;
    if (wr2) second_word[n2_q[ADDR_W-1:0]] <= in_sym;
  end

  // Feed registers: store reads and lane valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_feed_q <= '0;
      b_feed_q <= '0;
    end else begin
      a_feed_q.vld <= a_ok;
      a_feed_q.sym <= first_word[a_rel[ADDR_W-1:0]];
      a_feed_q.idx <= a_rel[ADDR_W-1:0];
      b_feed_q.vld <= b_ok;
      b_feed_q.sym <= second_word[b_rel[ADDR_W-1:0]];
    end
  end

  // Lengths and pass sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n1_q     <= '0;
      n2_q     <= '0;
      off_q    <= '0;
      tau_q    <= '0;
      a_base_q <= '0;
      b_base_q <= '0;
      tend_q   <= '0;
      k_q      <= '0;
      gb_q     <= '1;
      gsh_q    <= '0;
      gst_q    <= '0;
      gend_q   <= '0;
    end else begin
      if (wr1) n1_q <= n1_q + LEN_W'(1);
      if (wr2) n2_q <= n2_q + LEN_W'(1);
      unique case (state_q)
        ST_INIT: begin
          off_q  <= OFF_W'(n2_q) - OFF_W'(1);
          gb_q   <= '1;
          gsh_q  <= '0;
          gst_q  <= '0;
          gend_q <= '0;
        end
        ST_PREP: begin
          tau_q    <= '0;
          a_base_q <= a_base_d;
          b_base_q <= b_base_d;
          tend_q   <= a_base_d + TAU_W'(n1_q) + TAU_W'(NCELL + 2);
        end
        ST_RUN: begin
          tau_q <= tau_q + TAU_W'(1);
          k_q   <= '0;
        end
        ST_DRAIN: begin
          k_q <= k_q + CNT_W'(1);
          if (replace) begin
            gb_q   <= row_res.score;
            gsh_q  <= cshift;
            gst_q  <= row_res.first_idx;
            gend_q <= row_res.last_idx;
          end
          if (k_end) off_q <= off_q - OFF_W'(NCELL);
        end
        ST_DONE: begin
          if (done_ok) begin
            n1_q <= '0;
            n2_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (state_q == ST_DONE && done_ok) begin
      m_vld_q <= 1'b1;
    end else if (m_xfer) begin
      m_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && done_ok) begin
      m_data_q <= {4'b0, IDX_W'(gend_q), IDX_W'(gst_q), gsh_q[SHIFT_W-1:0],
                   SCORE_W'({gb_q, 1'b0})};
    end
  end

  udla_row u_row (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .a_i    (a_feed_q),
    .b_i    (b_feed_q),
    .res_o  (row_res)
  );

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = m_data_q;

  // A fresh result only ever comes from the completion state
  a_rise_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_vld_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside completion");

  // No match means all position fields are zero
  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gb_q == '1) |-> (gsh_q == '0 && gst_q == '0 && gend_q == '0))
    else $error("position recorded without a match");

  // Word lengths stay within the store
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n1_q <= LEN_W'(MAX_LEN)) && (n2_q <= LEN_W'(MAX_LEN)))
    else $error("word length beyond store depth");

  // Input is held off while an alignment is in progress
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN || state_q == ST_DRAIN) |=> !s_xfer || state_q == ST_LOAD)
    else $error("symbol taken during alignment");

endmodule
